FILE: sv/assert_macros.svh
// Assertion macros shared by the checker modules of the task queue.
// Each macro samples on clk; the first one is held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define PLQ_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("task queue check failed");

// Check a property on every clock edge, reset included
`define PLQ_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("task queue check failed during reset");

`endif

FILE: sv/plq_pkg.sv
// Package for the priority lane task queue: field widths, command and
// status codes, and the command and result beat types. No dependencies.
`timescale 1ns / 1ps

package plq_pkg;

    // Field widths of the command and result beats
    localparam int CMD_W    = 3;
    localparam int LANE_W   = 2;
    localparam int TASK_W   = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    // Default configuration of the queue
    localparam int LANE_COUNT_DEF = 3;
    localparam int LANE_DEPTH_DEF = 16;
    localparam int TASK_WIDTH_DEF = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_TAIL  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_HEAD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR_LANE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_COMPLETE   = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [LANE_W-1:0] lane;
        logic [TASK_W-1:0] task_id;
    } plq_req_t;

    typedef struct packed {
        logic                took_valid;
        logic [TASK_W-1:0]   task_out;
        logic [LANE_W-1:0]   lane_out;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  pending_count;
        logic [COUNT_W-1:0]  active_count;
        logic                idle;
    } plq_rsp_t;

endpackage

FILE: sv/priority_lane_task_queue.sv
// Top level of the priority lane task queue: lane pointers, counters and
// result registers around the lane store. Uses plq_pkg and plq_ram.
`timescale 1ns / 1ps

// The queue takes one command in every clock cycle: busy stays low, and a
// command is taken at each edge where start is high. Its result appears on
// rsp for exactly one cycle, with done high, in the cycle after the command
// was taken; the result comes from the registered read of the lane
// store, which a take command addresses in the cycle it is taken. Lane
// pointers, fills and counters are updated at the edge that takes the
// command, so commands may follow each other in every cycle with no gaps.
// The receiver cannot stall: a result that is not taken in its cycle is
// gone. No clearing pass runs after reset; lane slots are only read once
// they hold a pushed task.
module priority_lane_task_queue #(
    parameter int LANE_COUNT = plq_pkg::LANE_COUNT_DEF,
    parameter int LANE_DEPTH = plq_pkg::LANE_DEPTH_DEF,
    parameter int TASK_WIDTH = plq_pkg::TASK_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  plq_pkg::plq_req_t req,
    output logic              done,
    output plq_pkg::plq_rsp_t rsp
);

    localparam int HEAD_W  = $clog2(LANE_DEPTH);
    localparam int SUM_W   = HEAD_W + 1;
    localparam int FILL_W  = $clog2(LANE_DEPTH + 1);
    localparam int ENTRIES = LANE_COUNT * LANE_DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int PEND_W  = $clog2(ENTRIES + 1);
    localparam int LANE_W  = plq_pkg::LANE_W;
    localparam int TASK_W  = plq_pkg::TASK_W;
    localparam int COUNT_W = plq_pkg::COUNT_W;
    localparam int CNT_MAX = (2 ** COUNT_W) - 1;

    localparam logic [COUNT_W-1:0] RUN_MAX    = '1;
    localparam logic [SUM_W-1:0]   DEPTH_SUM  = SUM_W'(LANE_DEPTH);
    localparam logic [HEAD_W-1:0]  LAST_SLOT  = HEAD_W'(LANE_DEPTH - 1);
    localparam logic [FILL_W-1:0]  FULL_FILL  = FILL_W'(LANE_DEPTH);

    // Lane pointers and counters
    logic [HEAD_W-1:0]  head_reg  [LANE_COUNT];
    logic [HEAD_W-1:0]  head_next [LANE_COUNT];
    logic [FILL_W-1:0]  fill_reg  [LANE_COUNT];
    logic [FILL_W-1:0]  fill_next [LANE_COUNT];
    logic [PEND_W-1:0]  pend_reg;
    logic [PEND_W-1:0]  pend_next;
    logic [COUNT_W-1:0] run_reg;
    logic [COUNT_W-1:0] run_next;

    // Result registers
    logic                         done_reg;
    logic                         took_reg;
    logic                         took_next;
    logic [LANE_W-1:0]            lane_out_reg;
    logic [LANE_W-1:0]            lane_out_next;
    logic [plq_pkg::STATUS_W-1:0] status_reg;
    logic [plq_pkg::STATUS_W-1:0] status_next;

    // Per-lane decode
    logic [LANE_COUNT-1:0] lane_sel;
    logic [LANE_COUNT-1:0] lane_full;
    logic [LANE_COUNT-1:0] lane_pick;
    logic [HEAD_W-1:0]     back_slot  [LANE_COUNT];
    logic [HEAD_W-1:0]     front_slot [LANE_COUNT];
    logic [HEAD_W-1:0]     inc_slot   [LANE_COUNT];
    logic                  push_ok;
    logic                  any_ready;
    logic                  accept;

    // Lane store access
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [TASK_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [TASK_WIDTH-1:0] ram_rdata;

    logic [COUNT_W-1:0]    pend_sat;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Decode the addressed lane and the slot arithmetic of every lane
    always_comb
    begin
        logic [SUM_W-1:0] sum_back;
        logic [SUM_W-1:0] sum_inc;
        logic             found;
        found     = 1'b0;
        push_ok   = 1'b0;
        any_ready = 1'b0;
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            lane_sel[i]  = (int'(req.lane) == i);
            lane_full[i] = (fill_reg[i] == FULL_FILL);
            lane_pick[i] = (fill_reg[i] != '0) && !found;
            found        = found || (fill_reg[i] != '0);
            push_ok      = push_ok || (lane_sel[i] && !lane_full[i]);

            sum_back = SUM_W'(head_reg[i]) + SUM_W'(fill_reg[i]);
            sum_inc  = SUM_W'(head_reg[i]) + SUM_W'(1);
            back_slot[i] = (sum_back >= DEPTH_SUM) ? HEAD_W'(sum_back - DEPTH_SUM)
                                                   : HEAD_W'(sum_back);
            inc_slot[i]  = (sum_inc >= DEPTH_SUM) ? HEAD_W'(sum_inc - DEPTH_SUM)
                                                  : HEAD_W'(sum_inc);
            front_slot[i] = (head_reg[i] == '0) ? LAST_SLOT
                                                : head_reg[i] - HEAD_W'(1);
        end
        any_ready = found;
    end

    // Work out the next pointers, counters, store access and result
    always_comb
    begin
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            head_next[i] = head_reg[i];
            fill_next[i] = fill_reg[i];
        end
        pend_next     = pend_reg;
        run_next      = run_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        took_next     = 1'b0;
        lane_out_next = '0;
        status_next   = plq_pkg::STATUS_OK;
        ram_wdata     = TASK_WIDTH'(req.task_id);

        if (accept)
        begin
            case (req.cmd)
                plq_pkg::CMD_PUSH_TAIL,
                plq_pkg::CMD_PUSH_HEAD:
                begin
                    if (push_ok)
                    begin
                        ram_we    = 1'b1;
                        pend_next = pend_reg + PEND_W'(1);
                        for (int i = 0; i < LANE_COUNT; i++)
                        begin
                            if (lane_sel[i])
                            begin
                                fill_next[i] = fill_reg[i] + FILL_W'(1);
                                if (req.cmd == plq_pkg::CMD_PUSH_HEAD)
                                begin
                                    head_next[i] = front_slot[i];
                                    ram_waddr = ram_waddr | (ADDR_W'(i * LANE_DEPTH)
                                                + ADDR_W'(front_slot[i]));
                                end
                                else
                                begin
                                    ram_waddr = ram_waddr | (ADDR_W'(i * LANE_DEPTH)
                                                + ADDR_W'(back_slot[i]));
                                end
                            end
                        end
                    end
                    else
                    begin
                        status_next = plq_pkg::STATUS_FULL;
                    end
                end
                plq_pkg::CMD_TAKE:
                begin
                    if (any_ready)
                    begin
                        ram_re    = 1'b1;
                        took_next = 1'b1;
                        pend_next = pend_reg - PEND_W'(1);
                        if (run_reg != RUN_MAX)
                        begin
                            run_next = run_reg + COUNT_W'(1);
                        end
                        for (int i = 0; i < LANE_COUNT; i++)
                        begin
                            if (lane_pick[i])
                            begin
                                head_next[i]  = inc_slot[i];
                                fill_next[i]  = fill_reg[i] - FILL_W'(1);
                                lane_out_next = lane_out_next | LANE_W'(i);
                                ram_raddr = ram_raddr | (ADDR_W'(i * LANE_DEPTH)
                                            + ADDR_W'(head_reg[i]));
                            end
                        end
                    end
                    else
                    begin
                        status_next = plq_pkg::STATUS_EMPTY;
                    end
                end
                plq_pkg::CMD_CLEAR_ALL:
                begin
                    pend_next = '0;
                    for (int i = 0; i < LANE_COUNT; i++)
                    begin
                        head_next[i] = '0;
                        fill_next[i] = '0;
                    end
                end
                plq_pkg::CMD_CLEAR_LANE:
                begin
                    for (int i = 0; i < LANE_COUNT; i++)
                    begin
                        if (lane_sel[i])
                        begin
                            head_next[i] = '0;
                            fill_next[i] = '0;
                            pend_next    = pend_reg - PEND_W'(fill_reg[i]);
                        end
                    end
                end
                plq_pkg::CMD_COMPLETE:
                begin
                    if (run_reg != '0)
                    begin
                        run_next = run_reg - COUNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = plq_pkg::STATUS_OK;
                end
            endcase
        end
    end

    // Hold lane state, counters and the done register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_COUNT; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            pend_reg <= '0;
            run_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < LANE_COUNT; i++)
            begin
                head_reg[i] <= head_next[i];
                fill_reg[i] <= fill_next[i];
            end
            pend_reg <= pend_next;
            run_reg  <= run_next;
            done_reg <= accept;
        end
    end

    // Advance the result payload with each taken command
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            took_reg     <= took_next;
            lane_out_reg <= lane_out_next;
            status_reg   <= status_next;
        end
    end

    // Lane store: one region of LANE_DEPTH slots per lane
    plq_ram #(
        .WIDTH (TASK_WIDTH),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Saturate the pending total to the field width
    assign pend_sat = (32'(pend_reg) > CNT_MAX) ? RUN_MAX : COUNT_W'(pend_reg);

    // Drive the result beat
    assign done              = done_reg;
    assign rsp.took_valid    = took_reg;
    assign rsp.task_out      = took_reg ? TASK_W'(ram_rdata) : '0;
    assign rsp.lane_out      = lane_out_reg;
    assign rsp.status        = status_reg;
    assign rsp.pending_count = pend_sat;
    assign rsp.active_count  = run_reg;
    assign rsp.idle          = (pend_reg == '0) && (run_reg == '0);

endmodule

FILE: sv/plq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`timescale 1ns / 1ps

module plq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/plq_checker.sv
// Port-level checker for the priority lane task queue, bound to the top
// level. Uses plq_pkg and the macros of assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input plq_pkg::plq_rsp_t rsp
);

    logic accept;
    logic counts_zero;
    logic empty_beat;
    logic empty_clean;

    // Decode the handshake and the result fields
    assign accept      = start && !busy;
    assign counts_zero = (rsp.pending_count == '0) && (rsp.active_count == '0);
    assign empty_beat  = done && (rsp.status == plq_pkg::STATUS_EMPTY);
    assign empty_clean = !rsp.took_valid && (rsp.pending_count == '0)
                         && (rsp.task_out == '0);

    // Every taken command gives one result beat in the next cycle
    `PLQ_ASSERT(a_result_follows, accept |=> done)

    // No result beat without a command taken in the cycle before
    `PLQ_ASSERT(a_no_stray_result, done |-> $past(accept))

    // Idle agrees with both counts
    `PLQ_ASSERT(a_idle_counts, done |-> (rsp.idle == counts_zero))

    // A take that found every lane empty leaves nothing pending and returns nothing
    `PLQ_ASSERT(a_empty_take, empty_beat |-> empty_clean)

    // No result beat while reset is held
    `PLQ_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |-> (done !== 1'b1))

endmodule

bind priority_lane_task_queue plq_checker u_plq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

FILE: test/testbench.sv
// Self-checking bench for priority_lane_task_queue: a clocked driver, a result
// checker with its own lane predictor, and a watchdog on stalled progress.
// Depends on plq_pkg and the queue RTL only.
`timescale 1ns / 1ps

module testbench;

    localparam int LANES          = plq_pkg::LANE_COUNT_DEF;
    localparam int DEPTH          = plq_pkg::LANE_DEPTH_DEF;
    localparam int TARGET_CMDS    = 1450;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PRINT_LIMIT    = 40;

    // Command codes the queue ignores
    localparam logic [plq_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [plq_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    plq_pkg::plq_req_t req   = '0;
    logic              busy;
    logic              done;
    plq_pkg::plq_rsp_t rsp;

    priority_lane_task_queue DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // Mirror of the lane state
    logic [plq_pkg::TASK_W-1:0] lane_slots [LANES][DEPTH];
    int                         lane_head_q [LANES];
    int                         lane_fill_q [LANES];
    logic [5:0]                 running_q;
    logic [31:0]                finished_q;

    plq_pkg::plq_req_t pending_cmds [$];
    plq_pkg::plq_rsp_t expected_rsp [$];

    logic cmd_accepted = 1'b0;
    int   stim_items   = 0;
    int   issued       = 0;
    int   accepted     = 0;
    int   mismatches   = 0;
    int   idle_cycles  = 0;
    int   tasks_taken  = 0;
    int   pushes_rejected = 0;
    int   empty_takes  = 0;
    int   peak_active  = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Work out the result of one command and advance the mirrored lanes
    function automatic plq_pkg::plq_rsp_t queue_step(plq_pkg::plq_req_t c);
        plq_pkg::plq_rsp_t r;
        int                slot;
        int                total;
        bit                found;
        r     = '0;
        found = 1'b0;
        case (c.cmd)
            plq_pkg::CMD_PUSH_TAIL, plq_pkg::CMD_PUSH_HEAD:
            begin
                if (c.lane >= LANES)
                    r.status = plq_pkg::STATUS_FULL;
                else if (lane_fill_q[c.lane] >= DEPTH)
                    r.status = plq_pkg::STATUS_FULL;
                else if (c.cmd == plq_pkg::CMD_PUSH_TAIL)
                begin
                    slot = (lane_head_q[c.lane] + lane_fill_q[c.lane]) % DEPTH;
                    lane_slots[c.lane][slot] = c.task_id;
                    lane_fill_q[c.lane]++;
                end
                else
                begin
                    slot = (lane_head_q[c.lane] == 0) ? DEPTH - 1 : lane_head_q[c.lane] - 1;
                    lane_head_q[c.lane] = slot;
                    lane_slots[c.lane][slot] = c.task_id;
                    lane_fill_q[c.lane]++;
                end
            end
            plq_pkg::CMD_TAKE:
            begin
                r.status = plq_pkg::STATUS_EMPTY;
                for (int i = 0; i < LANES; i++)
                begin
                    if (!found && lane_fill_q[i] != 0)
                    begin
                        found        = 1'b1;
                        r.took_valid = 1'b1;
                        r.task_out   = lane_slots[i][lane_head_q[i]];
                        r.lane_out   = plq_pkg::LANE_W'(i);
                        r.status     = plq_pkg::STATUS_OK;
                        lane_head_q[i] = (lane_head_q[i] + 1) % DEPTH;
                        lane_fill_q[i]--;
                        if (running_q != 6'd63)
                            running_q++;
                    end
                end
            end
            plq_pkg::CMD_CLEAR_ALL:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    lane_fill_q[i] = 0;
                    lane_head_q[i] = 0;
                end
            end
            plq_pkg::CMD_CLEAR_LANE:
            begin
                if (c.lane < LANES)
                begin
                    lane_fill_q[c.lane] = 0;
                    lane_head_q[c.lane] = 0;
                end
            end
            plq_pkg::CMD_COMPLETE:
            begin
                if (running_q != 0)
                begin
                    running_q--;
                    finished_q++;
                end
            end
            default:
            begin
            end
        endcase
        total = 0;
        for (int i = 0; i < LANES; i++)
            total += lane_fill_q[i];
        if (total > 63)
            total = 63;
        r.pending_count = plq_pkg::COUNT_W'(total);
        r.active_count  = running_q;
        r.idle          = (total == 0 && running_q == 0);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Record accepted commands, check each result beat, watch for a stall
    always @(posedge clk)
    begin : track_results
        plq_pkg::plq_rsp_t want;
        logic              moved;
        moved = 1'b0;
        cmd_accepted <= rst_n && start && !busy;
        if (rst_n && start && !busy)
        begin
            expected_rsp.insert(expected_rsp.size(), queue_step(req));
            accepted++;
            moved = 1'b1;
        end
        if (rst_n && done)
        begin
            moved = 1'b1;
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t: result beat with none expected, actual %h", $time, rsp);
            end
            else
            begin
                want = expected_rsp[0];
                expected_rsp.delete(0);
                check_field("took_valid", want.took_valid, rsp.took_valid);
                check_field("task_out", want.task_out, rsp.task_out);
                check_field("lane_out", want.lane_out, rsp.lane_out);
                check_field("status", want.status, rsp.status);
                check_field("pending_count", want.pending_count, rsp.pending_count);
                check_field("active_count", want.active_count, rsp.active_count);
                check_field("idle", want.idle, rsp.idle);
                if (want.took_valid)
                    tasks_taken++;
                if (want.status == plq_pkg::STATUS_FULL)
                    pushes_rejected++;
                if (want.status == plq_pkg::STATUS_EMPTY)
                    empty_takes++;
                if (want.active_count > peak_active)
                    peak_active = want.active_count;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL priority_lane_task_queue");
            $finish;
        end
    end

    // Present the next command at the falling edge, with random gaps except while issued is 600 to 899
    always @(negedge clk)
    begin : drive_commands
        logic              next_start;
        plq_pkg::plq_req_t next_req;
        next_start = start;
        next_req   = req;
        if (rst_n && (!start || cmd_accepted))
        begin
            next_start = 1'b0;
            if (pending_cmds.size() != 0
                && ((issued >= 600 && issued < 900) || $urandom_range(0, 99) >= 10))
            begin
                next_start = 1'b1;
                next_req   = pending_cmds[0];
                pending_cmds.delete(0);
                issued++;
            end
        end
        start <= next_start;
        req   <= next_req;
    end

    // Queue one command; ignored ones do not count toward the total
    task automatic queue_cmd(logic [plq_pkg::CMD_W-1:0] c, logic [plq_pkg::LANE_W-1:0] l,
                             logic [plq_pkg::TASK_W-1:0] id);
        plq_pkg::plq_req_t item;
        item.cmd     = c;
        item.lane    = l;
        item.task_id = id;
        pending_cmds.insert(pending_cmds.size(), item);
        if (c <= plq_pkg::CMD_COMPLETE && !(c == plq_pkg::CMD_CLEAR_LANE && l >= LANES))
            stim_items++;
    endtask

    // Mostly real lanes, now and then the missing one
    function automatic logic [plq_pkg::LANE_W-1:0] pick_lane();
        return ($urandom_range(0, 15) == 0) ? plq_pkg::LANE_W'(3)
                                            : plq_pkg::LANE_W'($urandom_range(0, LANES - 1));
    endfunction

    // Pick one of the ignored command codes
    function automatic logic [plq_pkg::CMD_W-1:0] pick_spare();
        return $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    endfunction

    initial
    begin : run_test
        int unsigned roll;
        int unsigned count;
        logic [plq_pkg::LANE_W-1:0] burst_lane;

        running_q  = '0;
        finished_q = '0;
        for (int i = 0; i < LANES; i++)
        begin
            lane_head_q[i] = 0;
            lane_fill_q[i] = 0;
        end

        // Directed: empty take, idle complete, field extremes, missing lane, unused codes
        queue_cmd(plq_pkg::CMD_TAKE, 2'd0, 16'h0000);
        queue_cmd(plq_pkg::CMD_COMPLETE, 2'd3, 16'hFFFF);
        queue_cmd(plq_pkg::CMD_PUSH_TAIL, 2'd0, 16'hFFFF);
        queue_cmd(plq_pkg::CMD_PUSH_HEAD, 2'd0, 16'h0000);
        queue_cmd(plq_pkg::CMD_PUSH_TAIL, 2'd2, 16'h8001);
        queue_cmd(plq_pkg::CMD_PUSH_TAIL, 2'd1, 16'h7FFE);
        queue_cmd(plq_pkg::CMD_PUSH_TAIL, 2'd3, 16'hAAAA);
        queue_cmd(plq_pkg::CMD_PUSH_HEAD, 2'd3, 16'h5555);
        queue_cmd(plq_pkg::CMD_CLEAR_LANE, 2'd3, 16'h0000);
        queue_cmd(CMD_SPARE_LO, 2'd3, 16'hFFFF);
        queue_cmd(CMD_SPARE_HI, 2'd0, 16'h0000);
        queue_cmd(plq_pkg::CMD_TAKE, 2'd3, 16'hFFFF);
        queue_cmd(plq_pkg::CMD_TAKE, 2'd0, 16'h0000);
        queue_cmd(plq_pkg::CMD_TAKE, 2'd0, 16'h0000);
        queue_cmd(plq_pkg::CMD_COMPLETE, 2'd0, 16'h0000);
        queue_cmd(plq_pkg::CMD_CLEAR_LANE, 2'd2, 16'h0000);
        queue_cmd(plq_pkg::CMD_TAKE, 2'd0, 16'h0000);
        queue_cmd(plq_pkg::CMD_PUSH_HEAD, 2'd1, 16'h1234);
        queue_cmd(plq_pkg::CMD_PUSH_TAIL, 2'd2, 16'h5A5A);
        queue_cmd(plq_pkg::CMD_CLEAR_ALL, 2'd1, 16'h0000);
        queue_cmd(plq_pkg::CMD_COMPLETE, 2'd0, 16'h0000);
        queue_cmd(plq_pkg::CMD_COMPLETE, 2'd0, 16'h0000);
        queue_cmd(plq_pkg::CMD_COMPLETE, 2'd0, 16'h0000);

        // Overfill one lane, then take far more than complete to pin the active count
        for (int k = 0; k < DEPTH + 1; k++)
            queue_cmd(plq_pkg::CMD_PUSH_TAIL, 2'd0, plq_pkg::TASK_W'($urandom));
        for (int round = 0; round < 5; round++)
        begin
            burst_lane = plq_pkg::LANE_W'($urandom_range(0, LANES - 1));
            for (int k = 0; k < DEPTH; k++)
                queue_cmd($urandom_range(0, 1) ? plq_pkg::CMD_PUSH_TAIL : plq_pkg::CMD_PUSH_HEAD,
                          burst_lane, plq_pkg::TASK_W'($urandom));
            for (int k = 0; k < DEPTH + 1; k++)
                queue_cmd(plq_pkg::CMD_TAKE, pick_lane(), plq_pkg::TASK_W'($urandom));
        end
        for (int k = 0; k < 70; k++)
            queue_cmd(plq_pkg::CMD_COMPLETE, pick_lane(), plq_pkg::TASK_W'($urandom));

        // Random bursts: lane fills, drains, completions, clears and mixed traffic
        while (stim_items < TARGET_CMDS)
        begin
            roll = $urandom_range(0, 9);
            if (roll <= 2)
            begin
                burst_lane = pick_lane();
                count = $urandom_range(1, DEPTH + 2);
                for (int k = 0; k < count; k++)
                    queue_cmd($urandom_range(0, 1) ? plq_pkg::CMD_PUSH_TAIL
                                                   : plq_pkg::CMD_PUSH_HEAD,
                              burst_lane, plq_pkg::TASK_W'($urandom));
            end
            else if (roll <= 4)
            begin
                count = $urandom_range(1, 20);
                for (int k = 0; k < count; k++)
                    queue_cmd(plq_pkg::CMD_TAKE, pick_lane(), plq_pkg::TASK_W'($urandom));
            end
            else if (roll == 5)
            begin
                count = $urandom_range(1, 12);
                for (int k = 0; k < count; k++)
                    queue_cmd(plq_pkg::CMD_COMPLETE, pick_lane(), plq_pkg::TASK_W'($urandom));
            end
            else if (roll == 6)
            begin
                queue_cmd($urandom_range(0, 3) == 0 ? plq_pkg::CMD_CLEAR_ALL
                                                    : plq_pkg::CMD_CLEAR_LANE,
                          plq_pkg::LANE_W'($urandom_range(0, 3)), plq_pkg::TASK_W'($urandom));
                queue_cmd(pick_spare(), plq_pkg::LANE_W'($urandom_range(0, 3)),
                          plq_pkg::TASK_W'($urandom));
            end
            else
            begin
                count = $urandom_range(4, 30);
                for (int k = 0; k < count; k++)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 22)
                        queue_cmd(plq_pkg::CMD_PUSH_TAIL, pick_lane(),
                                  plq_pkg::TASK_W'($urandom));
                    else if (roll < 40)
                        queue_cmd(plq_pkg::CMD_PUSH_HEAD, pick_lane(),
                                  plq_pkg::TASK_W'($urandom));
                    else if (roll < 70)
                        queue_cmd(plq_pkg::CMD_TAKE, pick_lane(), plq_pkg::TASK_W'($urandom));
                    else if (roll < 88)
                        queue_cmd(plq_pkg::CMD_COMPLETE, pick_lane(),
                                  plq_pkg::TASK_W'($urandom));
                    else if (roll < 93)
                        queue_cmd(plq_pkg::CMD_CLEAR_LANE,
                                  plq_pkg::LANE_W'($urandom_range(0, 3)),
                                  plq_pkg::TASK_W'($urandom));
                    else if (roll < 95)
                        queue_cmd(plq_pkg::CMD_CLEAR_ALL, pick_lane(),
                                  plq_pkg::TASK_W'($urandom));
                    else
                        queue_cmd(pick_spare(), plq_pkg::LANE_W'($urandom_range(0, 3)),
                                  plq_pkg::TASK_W'($urandom));
                end
            end
        end

        // Hold reset, then release it away from the rising edge
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Drain: every command accepted and every result checked
        while (pending_cmds.size() != 0 || start || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Ran %0d commands: %0d tasks taken, %0d pushes rejected, %0d empty takes,",
                 accepted, tasks_taken, pushes_rejected, empty_takes);
        $display("peak active count %0d, %0d mismatches", peak_active, mismatches);
        if (mismatches == 0)
            $display("PASS priority_lane_task_queue");
        else
            $display("FAIL priority_lane_task_queue");
        $finish;
    end

endmodule
